[hw/rtl/acws_pkg.sv]
`timescale 1ns / 1ps

package acws_pkg;

  localparam int BTN_W  = 4;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;
  localparam int SEG_W  = 8;
  localparam int LED_W  = 10;
  localparam int DIG_W  = 4;

  localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;
  localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
  localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;
  localparam logic [LED_W-1:0]  LED_ALL   = 10'h3FF;
  localparam logic [SEG_W-1:0]  SEG_BLANK = 8'hFF;

  localparam int BTN_SEC   = 0;
  localparam int BTN_MIN   = 1;
  localparam int BTN_HOUR  = 2;
  localparam int BTN_ALARM = 3;

  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
  } tod_t;

  typedef struct packed {
    tod_t             now;
    logic [LED_W-1:0] leds;
  } core_res_t;

  typedef struct packed {
    logic [SEG_W-1:0] hour_tens;
    logic [SEG_W-1:0] hour_units;
    logic [SEG_W-1:0] min_tens;
    logic [SEG_W-1:0] min_units;
    logic [SEG_W-1:0] sec_tens;
    logic [SEG_W-1:0] sec_units;
  } seg_bytes_t;

  // Active-low segment byte, bit0 is segment a, bit7 is the unused dot.
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] digit);
    logic [SEG_W-1:0] pattern;
    begin
      unique case (digit)
        4'd0: pattern = 8'h3F;
        4'd1: pattern = 8'h06;
        4'd2: pattern = 8'h5B;
        4'd3: pattern = 8'h4F;
        4'd4: pattern = 8'h66;
        4'd5: pattern = 8'h6D;
        4'd6: pattern = 8'h7D;
        4'd7: pattern = 8'h07;
        4'd8: pattern = 8'h7F;
        4'd9: pattern = 8'h6F;
        default: pattern = 8'h00;
      endcase
      seg_of = (digit > 4'd9) ? SEG_BLANK : ~pattern;
    end
  endfunction

  function automatic logic [DIG_W-1:0] tens_of(input logic [5:0] v);
    logic [DIG_W-1:0] t;
    begin
      priority if (v >= 6'd60) t = 4'd6;
      else if (v >= 6'd50) t = 4'd5;
      else if (v >= 6'd40) t = 4'd4;
      else if (v >= 6'd30) t = 4'd3;
      else if (v >= 6'd20) t = 4'd2;
      else if (v >= 6'd10) t = 4'd1;
      else t = 4'd0;
      tens_of = t;
    end
  endfunction

  function automatic logic [DIG_W-1:0] units_of(input logic [5:0] v);
    logic [5:0] tens_x10;
    logic [5:0] rem;
    begin
      tens_x10 = 6'(tens_of(v)) * 6'd10;
      rem      = v - tens_x10;
      units_of = rem[DIG_W-1:0];
    end
  endfunction

endpackage

[hw/rtl/acws_in_if.sv]
`timescale 1ns / 1ps

interface acws_in_if import acws_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] buttons;
  logic             run_switch;
  logic             second_tick;

  modport source (output valid, output buttons, output run_switch, output second_tick,
                  input ready);
  modport sink (input valid, input buttons, input run_switch, input second_tick,
                output ready);
endinterface

[hw/rtl/acws_out_if.sv]
`timescale 1ns / 1ps

interface acws_out_if import acws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SEG_W-1:0]  hour_tens_seg;
  logic [SEG_W-1:0]  hour_units_seg;
  logic [SEG_W-1:0]  min_tens_seg;
  logic [SEG_W-1:0]  min_units_seg;
  logic [SEG_W-1:0]  sec_tens_seg;
  logic [SEG_W-1:0]  sec_units_seg;
  logic [LED_W-1:0]  alarm_leds;
  logic [HOUR_W-1:0] hours_now;
  logic [MIN_W-1:0]  minutes_now;
  logic [SEC_W-1:0]  seconds_now;

  modport source (output valid, output hour_tens_seg, output hour_units_seg,
                  output min_tens_seg, output min_units_seg, output sec_tens_seg,
                  output sec_units_seg, output alarm_leds, output hours_now,
                  output minutes_now, output seconds_now, input ready);
  modport sink (input valid, input hour_tens_seg, input hour_units_seg,
                input min_tens_seg, input min_units_seg, input sec_tens_seg,
                input sec_units_seg, input alarm_leds, input hours_now,
                input minutes_now, input seconds_now, output ready);
endinterface

[hw/rtl/acws_core.sv]
`timescale 1ns / 1ps

module acws_core import acws_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [BTN_W-1:0] buttons,
  input  logic             run_switch,
  input  logic             second_tick,
  output core_res_t        res
);

  tod_t             time_r, time_nxt;
  tod_t             alarm_r, alarm_nxt;
  logic             alarm_set_r, alarm_set_nxt;
  logic [BTN_W-1:0] prev_btn_r, prev_btn_nxt;
  logic             prev_run_r, prev_run_nxt;
  logic             counting_r, counting_nxt;
  logic [LED_W-1:0] led_r, led_nxt;
  logic [BTN_W-1:0] rise;

  always_comb begin
    time_nxt      = time_r;
    alarm_nxt     = alarm_r;
    alarm_set_nxt = alarm_set_r;
    led_nxt       = led_r;
    counting_nxt  = counting_r;
    prev_run_nxt  = prev_run_r;
    prev_btn_nxt  = buttons;
    rise          = buttons & ~prev_btn_r;

    if (!run_switch) begin
      if (rise[BTN_SEC]) begin
        time_nxt.seconds = (time_nxt.seconds == SEC_LAST) ? '0 : time_nxt.seconds + 6'd1;
      end
      if (rise[BTN_MIN]) begin
        time_nxt.minutes = (time_nxt.minutes == MIN_LAST) ? '0 : time_nxt.minutes + 6'd1;
      end
      if (rise[BTN_HOUR]) begin
        time_nxt.hours = (time_nxt.hours == HOUR_LAST) ? '0 : time_nxt.hours + 5'd1;
      end
      if (rise[BTN_ALARM]) begin
        alarm_nxt     = time_nxt;
        alarm_set_nxt = 1'b1;
      end
    end else if (rise[BTN_ALARM]) begin
      led_nxt = '0;
    end

    if (run_switch != prev_run_r) begin
      counting_nxt = run_switch;
      prev_run_nxt = run_switch;
    end

    // The tick carries seconds into minutes into hours.
    if (counting_nxt && second_tick) begin
      if (time_nxt.seconds >= SEC_LAST) begin
        time_nxt.seconds = '0;
        if (time_nxt.minutes >= MIN_LAST) begin
          time_nxt.minutes = '0;
          time_nxt.hours = (time_nxt.hours >= HOUR_LAST) ? '0 : time_nxt.hours + 5'd1;
        end else begin
          time_nxt.minutes = time_nxt.minutes + 6'd1;
        end
      end else begin
        time_nxt.seconds = time_nxt.seconds + 6'd1;
      end
    end

    if (alarm_set_nxt && run_switch && (alarm_nxt == time_nxt)) begin
      led_nxt = LED_ALL;
    end

    res.now  = time_nxt;
    res.leds = led_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      alarm_r     <= '0;
      alarm_set_r <= 1'b0;
      prev_btn_r  <= '0;
      prev_run_r  <= 1'b0;
      counting_r  <= 1'b0;
      led_r       <= '0;
    end else if (accept) begin
      time_r      <= time_nxt;
      alarm_r     <= alarm_nxt;
      alarm_set_r <= alarm_set_nxt;
      prev_btn_r  <= prev_btn_nxt;
      prev_run_r  <= prev_run_nxt;
      counting_r  <= counting_nxt;
      led_r       <= led_nxt;
    end
  end

endmodule

[hw/rtl/acws_seg.sv]
`timescale 1ns / 1ps

module acws_seg import acws_pkg::*; (
  input  tod_t       now,
  output seg_bytes_t segs
);

  logic [5:0] hours_ext;

  assign hours_ext = {1'b0, now.hours};

  always_comb begin
    segs.hour_tens  = seg_of(tens_of(hours_ext));
    segs.hour_units = seg_of(units_of(hours_ext));
    segs.min_tens   = seg_of(tens_of(now.minutes));
    segs.min_units  = seg_of(units_of(now.minutes));
    segs.sec_tens   = seg_of(tens_of(now.seconds));
    segs.sec_units  = seg_of(units_of(now.seconds));
  end

endmodule

[hw/rtl/alarm_clock_with_seven_segment.sv]
`timescale 1ns / 1ps
// Latency: the result of a transaction is valid in the cycle after it is accepted.
// Throughput: one transaction per cycle unless out_ch.ready stalls; the clock state
// update and the digit encoding form one registered pass between the input handshake
// and the result register. Reset: synchronous, active low; clears time, alarm, LED and
// edge state and empties the result register.
module alarm_clock_with_seven_segment import acws_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  acws_in_if.sink    in_ch,
  acws_out_if.source out_ch
);

  logic       accept;
  logic       out_valid_r;
  core_res_t  res;
  seg_bytes_t segs;
  core_res_t  res_r;
  seg_bytes_t segs_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  acws_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .buttons     (in_ch.buttons),
    .run_switch  (in_ch.run_switch),
    .second_tick (in_ch.second_tick),
    .res         (res)
  );

  acws_seg u_seg (
    .now  (res.now),
    .segs (segs)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r  <= res;
      segs_r <= segs;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hour_tens_seg  = segs_r.hour_tens;
  assign out_ch.hour_units_seg = segs_r.hour_units;
  assign out_ch.min_tens_seg   = segs_r.min_tens;
  assign out_ch.min_units_seg  = segs_r.min_units;
  assign out_ch.sec_tens_seg   = segs_r.sec_tens;
  assign out_ch.sec_units_seg  = segs_r.sec_units;
  assign out_ch.alarm_leds     = res_r.leds;
  assign out_ch.hours_now      = res_r.now.hours;
  assign out_ch.minutes_now    = res_r.now.minutes;
  assign out_ch.seconds_now    = res_r.now.seconds;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.now.hours <= HOUR_LAST && res_r.now.minutes <= MIN_LAST &&
                     res_r.now.seconds <= SEC_LAST))
    else $error("time of day out of range");

  a_leds_all_or_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.leds == '0 || res_r.leds == LED_ALL))
    else $error("alarm LEDs partly lit");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result register not empty after reset");

endmodule

[tb/sv/tb_alarm_clock_with_seven_segment.sv]
`timescale 1ns / 1ps

module tb_alarm_clock_with_seven_segment;
  import acws_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int MAX_REPORTS  = 10;

  localparam logic [BTN_W-1:0] SEC_KEY   = BTN_W'(1 << BTN_SEC);
  localparam logic [BTN_W-1:0] MIN_KEY   = BTN_W'(1 << BTN_MIN);
  localparam logic [BTN_W-1:0] HOUR_KEY  = BTN_W'(1 << BTN_HOUR);
  localparam logic [BTN_W-1:0] ALARM_KEY = BTN_W'(1 << BTN_ALARM);
  localparam logic [BTN_W-1:0] NO_KEYS   = '0;
  localparam logic [BTN_W-1:0] ALL_KEYS  = '1;

  typedef struct packed {
    seg_bytes_t       segs;
    logic [LED_W-1:0] leds;
    tod_t             now;
  } display_t;

  logic clk = 1'b0;
  logic rst_n;

  acws_in_if  in_ch ();
  acws_out_if out_ch ();

  alarm_clock_with_seven_segment uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  display_t         expected_displays[$];
  tod_t             time_of_day;
  tod_t             alarm_time;
  logic             alarm_armed;
  logic [BTN_W-1:0] last_buttons;
  logic             last_run;
  logic             ticking;
  logic [LED_W-1:0] led_reg;

  int  cycles      = 0;
  int  mismatches  = 0;
  int  items_sent  = 0;
  bit  no_idle     = 1'b0;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [SEG_W-1:0] digit_segments(input int unsigned d);
    logic [SEG_W-1:0] lit;
    case (d)
      0: lit = 8'h3F;
      1: lit = 8'h06;
      2: lit = 8'h5B;
      3: lit = 8'h4F;
      4: lit = 8'h66;
      5: lit = 8'h6D;
      6: lit = 8'h7D;
      7: lit = 8'h07;
      8: lit = 8'h7F;
      9: lit = 8'h6F;
      default: lit = 8'h00;
    endcase
    return (d > 9) ? 8'hFF : ~lit;
  endfunction

  function automatic logic [5:0] wrap_inc(input logic [5:0] v, input logic [5:0] top);
    return (v == top) ? 6'd0 : v + 6'd1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  task automatic clock_reset_state();
    time_of_day  = '0;
    alarm_time   = '0;
    alarm_armed  = 1'b0;
    last_buttons = '0;
    last_run     = 1'b0;
    ticking      = 1'b0;
    led_reg      = '0;
  endtask

  task automatic advance_clock(input logic [BTN_W-1:0] btn, input logic run,
                               input logic tick);
    logic [BTN_W-1:0] rise;
    display_t         d;
    rise = btn & ~last_buttons;
    if (!run) begin
      if (rise[BTN_SEC])
        time_of_day.seconds = wrap_inc(time_of_day.seconds, SEC_LAST);
      if (rise[BTN_MIN])
        time_of_day.minutes = wrap_inc(time_of_day.minutes, MIN_LAST);
      if (rise[BTN_HOUR])
        time_of_day.hours = HOUR_W'(wrap_inc(6'(time_of_day.hours), 6'(HOUR_LAST)));
      if (rise[BTN_ALARM]) begin
        alarm_time  = time_of_day;
        alarm_armed = 1'b1;
      end
    end else if (rise[BTN_ALARM] && led_reg != '0) begin
      led_reg = '0;
    end
    last_buttons = btn;

    if (run != last_run) begin
      ticking  = run;
      last_run = run;
    end

    if (ticking && tick) begin
      time_of_day.seconds = wrap_inc(time_of_day.seconds, SEC_LAST);
      if (time_of_day.seconds == '0) begin
        time_of_day.minutes = wrap_inc(time_of_day.minutes, MIN_LAST);
        if (time_of_day.minutes == '0)
          time_of_day.hours = HOUR_W'(wrap_inc(6'(time_of_day.hours), 6'(HOUR_LAST)));
      end
    end

    if (alarm_armed && run && alarm_time == time_of_day)
      led_reg = LED_ALL;

    d.segs.hour_tens  = digit_segments(int'(time_of_day.hours) / 10);
    d.segs.hour_units = digit_segments(int'(time_of_day.hours) % 10);
    d.segs.min_tens   = digit_segments(int'(time_of_day.minutes) / 10);
    d.segs.min_units  = digit_segments(int'(time_of_day.minutes) % 10);
    d.segs.sec_tens   = digit_segments(int'(time_of_day.seconds) / 10);
    d.segs.sec_units  = digit_segments(int'(time_of_day.seconds) % 10);
    d.leds            = led_reg;
    d.now             = time_of_day;
    expected_displays.push_back(d);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want)
      report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  task automatic check_display();
    display_t want;
    if (expected_displays.size() == 0) begin
      report_mismatch("result transaction with no expected result");
      return;
    end
    want = expected_displays.pop_front();
    compare_field("hour_tens_seg", 16'(want.segs.hour_tens), 16'(out_ch.hour_tens_seg));
    compare_field("hour_units_seg", 16'(want.segs.hour_units), 16'(out_ch.hour_units_seg));
    compare_field("min_tens_seg", 16'(want.segs.min_tens), 16'(out_ch.min_tens_seg));
    compare_field("min_units_seg", 16'(want.segs.min_units), 16'(out_ch.min_units_seg));
    compare_field("sec_tens_seg", 16'(want.segs.sec_tens), 16'(out_ch.sec_tens_seg));
    compare_field("sec_units_seg", 16'(want.segs.sec_units), 16'(out_ch.sec_units_seg));
    compare_field("alarm_leds", 16'(want.leds), 16'(out_ch.alarm_leds));
    compare_field("hours_now", 16'(want.now.hours), 16'(out_ch.hours_now));
    compare_field("minutes_now", 16'(want.now.minutes), 16'(out_ch.minutes_now));
    compare_field("seconds_now", 16'(want.now.seconds), 16'(out_ch.seconds_now));
  endtask

  initial begin : display_monitor
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        check_display();
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  task automatic send_item(input logic [BTN_W-1:0] btn, input logic run, input logic tick);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.buttons     <= btn;
    in_ch.run_switch  <= run;
    in_ch.second_tick <= tick;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    advance_clock(btn, run, tick);
    items_sent++;
  endtask

  task automatic wait_all_displays();
    in_ch.valid <= 1'b0;
    while (expected_displays.size() != 0) @(posedge clk);
  endtask

  task automatic press_button(input logic [BTN_W-1:0] mask, input logic run);
    send_item(mask, run, 1'($urandom_range(0, 1)));
    send_item(NO_KEYS, run, 1'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(input int n, input int tick_pct, input int clear_pct);
    logic [BTN_W-1:0] btn;
    repeat (n) begin
      if (int'($urandom_range(0, 99)) < clear_pct)
        btn = ALARM_KEY;
      else if ($urandom_range(0, 9) == 0)
        btn = BTN_W'($urandom_range(0, 15));
      else
        btn = NO_KEYS;
      send_item(btn, 1'b1, int'($urandom_range(0, 99)) < tick_pct);
    end
  endtask

  task automatic drive_to_time(input tod_t target);
    logic [BTN_W-1:0] mask;
    forever begin
      mask = NO_KEYS;
      if (time_of_day.seconds != target.seconds) mask |= SEC_KEY;
      if (time_of_day.minutes != target.minutes) mask |= MIN_KEY;
      if (time_of_day.hours != target.hours)     mask |= HOUR_KEY;
      if (mask == NO_KEYS) break;
      press_button(mask, 1'b0);
    end
  endtask

  task automatic test_power_on();
    send_item(NO_KEYS, 1'b0, 1'b0);
    send_item(NO_KEYS, 1'b0, 1'b1);
  endtask

  task automatic test_set_buttons();
    press_button(SEC_KEY, 1'b0);
    press_button(MIN_KEY, 1'b0);
    press_button(HOUR_KEY, 1'b0);
    send_item(SEC_KEY, 1'b0, 1'b0);
    send_item(SEC_KEY, 1'b0, 1'b1);
    send_item(NO_KEYS, 1'b0, 1'b0);
    send_item(ALL_KEYS, 1'b0, 1'b0);
    send_item(NO_KEYS, 1'b0, 1'b0);
  endtask

  task automatic test_alarm_fire_and_clear();
    send_item(NO_KEYS, 1'b1, 1'b0);
    send_item(ALARM_KEY, 1'b1, 1'b1);
    send_item(NO_KEYS, 1'b1, 1'b1);
    send_item(ALARM_KEY, 1'b1, 1'b0);
    send_item(SEC_KEY | MIN_KEY | HOUR_KEY, 1'b1, 1'b0);
    send_item(NO_KEYS, 1'b1, 1'b0);
    send_item(NO_KEYS, 1'b0, 1'b1);
  endtask

  task automatic test_random_traffic();
    int   stop_at;
    int   pick;
    bit   paused;
    tod_t target;
    stop_at = items_sent + RANDOM_ITEMS;
    paused  = 1'b0;
    while (items_sent < stop_at) begin
      no_idle = ($urandom_range(0, 99) < 15);
      if (!paused && items_sent > stop_at - RANDOM_ITEMS / 2) begin
        wait_all_displays();
        paused = 1'b1;
      end
      pick = int'($urandom_range(0, 99));
      if (pick < 35) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 1)
            press_button(BTN_W'(1 << $urandom_range(0, 2)), 1'b0);
          else
            press_button(BTN_W'($urandom_range(1, 7)), 1'b0);
        end
        press_button(ALARM_KEY | BTN_W'($urandom_range(0, 7)), 1'b0);
        run_phase(int'($urandom_range(5, 40)), int'($urandom_range(0, 80)), 15);
      end else if (pick < 55) begin
        case ($urandom_range(0, 3))
          0, 1: target = '{hours: HOUR_LAST, minutes: MIN_LAST,
                           seconds: SEC_W'($urandom_range(55, 59))};
          2: target = '{hours: HOUR_W'($urandom_range(0, 23)), minutes: MIN_LAST,
                        seconds: SEC_W'($urandom_range(55, 59))};
          default: target = '{hours: HOUR_W'($urandom_range(0, 23)),
                              minutes: MIN_W'($urandom_range(0, 59)),
                              seconds: SEC_W'($urandom_range(0, 59))};
        endcase
        drive_to_time(target);
        if ($urandom_range(0, 1) == 1)
          press_button(ALARM_KEY, 1'b0);
        run_phase(int'($urandom_range(10, 40)), 70, 8);
      end else if (pick < 70) begin
        run_phase(int'($urandom_range(5, 20)), 10, 40);
      end else if (pick < 85) begin
        repeat ($urandom_range(5, 20))
          send_item(BTN_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(4, 12))
          send_item(BTN_W'($urandom_range(0, 15)), ~last_run, 1'($urandom_range(0, 1)));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clock_reset_state();
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.buttons     = '0;
    in_ch.run_switch  = 1'b0;
    in_ch.second_tick = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_power_on();
    test_set_buttons();
    test_alarm_fire_and_clear();
    test_random_traffic();

    wait_all_displays();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_displays.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
